[rtl/core/met_pkg.sv]
// ----------------------------------------------------------------------------
// met_pkg
// Shared widths, register indexes and reset values of the escape-time core.
// ----------------------------------------------------------------------------
package met_pkg;

	localparam int TAG_BITS       = 24;
	localparam int CENTER_BITS    = 13;
	localparam int SCALE_BITS     = 28;
	localparam int LIMIT_BITS     = 12;
	localparam int COUNT_OUT_BITS = 12;
	localparam int COLOR_BITS     = 8;

	localparam int CFG_IDX_BITS  = 8;
	localparam int CFG_DATA_BITS = 28;

	localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X       = 8'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y       = 8'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PIXEL_SCALE    = 8'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_ITERATION_LIMIT = 8'd3;

	localparam logic [CENTER_BITS-1:0] CENTER_X_RESET        = 13'd700;
	localparam logic [CENTER_BITS-1:0] CENTER_Y_RESET        = 13'd910;
	localparam logic [SCALE_BITS-1:0]  PIXEL_SCALE_RESET     = 28'd223696;
	localparam logic [LIMIT_BITS-1:0]  ITERATION_LIMIT_RESET = 12'd100;

endpackage

[rtl/core/met_if.sv]
// ----------------------------------------------------------------------------
// met_if
// Channel interfaces of the escape-time core: pixel words in, result words
// out and register writes.
// ----------------------------------------------------------------------------
interface met_pixel_if import met_pkg::*; #(parameter int COORD_BITS = 12);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic [TAG_BITS-1:0]   pixel_tag;

	modport source (output valid, output pixel_x, output pixel_y, output pixel_tag,
		input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input pixel_tag,
		output ready);
endinterface

interface met_result_if import met_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [TAG_BITS-1:0]       result_tag;
	logic                      in_set;
	logic [COUNT_OUT_BITS-1:0] iteration_count;
	logic [COLOR_BITS-1:0]     color_index;

	modport source (output valid, output result_tag, output in_set,
		output iteration_count, output color_index, input ready);
	modport sink (input valid, input result_tag, input in_set,
		input iteration_count, input color_index, output ready);
endinterface

interface met_cfg_if import met_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/mandelbrot_escape_time_core.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core
// Escape-time evaluator for one pixel at a time on a single shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
// A pixel word (column, row, tag) enters on the pixel channel. The core maps
// it to c = (pixel - center) * scale, clamps each part to +/-8 and iterates
// z' = z^2 + c until the squared magnitude exceeds 4 or the limit is reached.
// One result word (tag, in-set flag, count, color index) leaves on the result
// channel for every pixel word.
// Sequence: the pixel word is taken in the idle state; the point is then
// mapped on the one multiplier, each iteration uses it for a*a, b*b and a*b
// before the test and update, an escaped pixel then passes through the
// bit-serial color divider, and the output register is loaded last. The
// failing test of an escaped pixel is one more pass of the loop, which is
// not counted; the multiplier loop sets the rate.
// Ready is low while a pixel is at work.
// A finished word waits in the output register while the next pixel word is
// taken; if the receiver still holds off when the next one is done, the core
// waits before its load. Register writes are taken in every cycle.
// Reset clears the handshake state and restores the register reset values.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_core import met_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 27,
	parameter int COUNT_BITS = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	met_pixel_if.sink     pixel,
	met_result_if.source  result,
	met_cfg_if.sink       cfg
);

	// Values stay within 12 in magnitude: four integer bits and a sign.
	localparam int W  = FRAC_BITS + 5;
	localparam int MW = (W > SCALE_BITS + 1) ? W : SCALE_BITS + 1;
	localparam int PW = 2 * MW;
	localparam int SW = 2 * W - FRAC_BITS;
	localparam int DW = ((COORD_BITS > CENTER_BITS) ? COORD_BITS : CENTER_BITS) + 1;
	localparam int LW = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
	localparam int NW = COUNT_BITS + COLOR_BITS;

	localparam logic signed [PW-1:0] LIM  = PW'(8) << FRAC_BITS;
	localparam logic signed [PW-1:0] NLIM = -LIM;
	localparam logic signed [SW:0]   FOUR = (SW + 1)'(4) << FRAC_BITS;
	localparam logic [LW-1:0]        CMAX = LW'((1 << COUNT_BITS) - 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MX   = 4'd1;
	localparam logic [3:0] S_MY   = 4'd2;
	localparam logic [3:0] S_CY   = 4'd3;
	localparam logic [3:0] S_AA   = 4'd4;
	localparam logic [3:0] S_BB   = 4'd5;
	localparam logic [3:0] S_AB   = 4'd6;
	localparam logic [3:0] S_TS   = 4'd7;
	localparam logic [3:0] S_DIV  = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	logic [3:0] state_q;

	logic [CENTER_BITS-1:0] center_x_q;
	logic [CENTER_BITS-1:0] center_y_q;
	logic [SCALE_BITS-1:0]  pixel_scale_q;
	logic [LIMIT_BITS-1:0]  iteration_limit_q;

	logic [COORD_BITS-1:0] px_q;
	logic [COORD_BITS-1:0] py_q;
	logic [TAG_BITS-1:0]   tag_q;

	logic signed [W-1:0]  cx_q;
	logic signed [W-1:0]  cy_q;
	logic signed [W-1:0]  a_q;
	logic signed [W-1:0]  b_q;
	logic signed [SW-1:0] aa_q;
	logic signed [SW-1:0] bb_q;
	logic signed [PW-1:0] prod_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  inside_q;

	logic [NW-1:0]         rem_q;
	logic [NW-1:0]         dsh_q;
	logic [COLOR_BITS-1:0] quo_q;
	logic [2:0]            div_step_q;

	logic                      res_valid_q;
	logic [TAG_BITS-1:0]       res_tag_q;
	logic                      res_in_set_q;
	logic [COUNT_OUT_BITS-1:0] res_count_q;
	logic [COLOR_BITS-1:0]     res_color_q;

	logic signed [DW-1:0] diff_x;
	logic signed [DW-1:0] diff_y;
	logic signed [MW-1:0] op_a;
	logic signed [MW-1:0] op_b;
	logic signed [MW-1:0] scale_op;
	logic signed [PW-1:0] mul_p;
	logic signed [W-1:0]  clamp_c;
	logic signed [SW:0]   mag;
	logic signed [SW-1:0] ab2;
	logic signed [SW-1:0] next_a;
	logic signed [SW-1:0] next_b;
	logic [LW-1:0]         limit_w;
	logic [COUNT_BITS-1:0] limit_eff;
	logic [COUNT_BITS-1:0] count_inc;
	logic [COUNT_BITS-1:0] den;
	logic [NW-1:0]         num;
	logic                  div_ge;
	logic                  out_free;

	assign pixel.ready = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;

	assign result.valid           = res_valid_q;
	assign result.result_tag      = res_tag_q;
	assign result.in_set          = res_in_set_q;
	assign result.iteration_count = res_count_q;
	assign result.color_index     = res_color_q;

	assign limit_w   = LW'(iteration_limit_q);
	assign limit_eff = COUNT_BITS'((limit_w > CMAX) ? CMAX : limit_w);
	assign count_inc = count_q + 1'b1;

	assign diff_x   = $signed(DW'(px_q)) - $signed(DW'(center_x_q));
	assign diff_y   = $signed(DW'(py_q)) - $signed(DW'(center_y_q));
	assign scale_op = $signed(MW'(pixel_scale_q));

	always_comb begin
		case (state_q)
			S_MX: begin
				op_a = MW'(diff_x);
				op_b = scale_op;
			end
			S_MY: begin
				op_a = MW'(diff_y);
				op_b = scale_op;
			end
			S_AA: begin
				op_a = MW'(a_q);
				op_b = MW'(a_q);
			end
			S_BB: begin
				op_a = MW'(b_q);
				op_b = MW'(b_q);
			end
			S_AB: begin
				op_a = MW'(a_q);
				op_b = MW'(b_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign mul_p = op_a * op_b;

	always_comb begin
		if (prod_q > LIM) begin
			clamp_c = W'(LIM);
		end else if (prod_q < NLIM) begin
			clamp_c = W'(NLIM);
		end else begin
			clamp_c = W'(prod_q);
		end
	end

	// Arithmetic shifts give the floor of each exact product.
	assign mag    = (SW + 1)'(aa_q) + (SW + 1)'(bb_q);
	assign ab2    = SW'(prod_q >>> (FRAC_BITS - 1));
	assign next_a = aa_q - bb_q + SW'(cy_q);
	assign next_b = ab2 + SW'(cx_q);

	assign den    = limit_eff - 1'b1;
	assign num    = NW'({count_q, 8'h00}) - NW'(count_q);
	assign div_ge = (rem_q >= dsh_q);

	assign out_free = !res_valid_q || result.ready;

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q        <= CENTER_X_RESET;
			center_y_q        <= CENTER_Y_RESET;
			pixel_scale_q     <= PIXEL_SCALE_RESET;
			iteration_limit_q <= ITERATION_LIMIT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CENTER_X:        center_x_q        <= cfg.data[CENTER_BITS-1:0];
				REG_CENTER_Y:        center_y_q        <= cfg.data[CENTER_BITS-1:0];
				REG_PIXEL_SCALE:     pixel_scale_q     <= cfg.data[SCALE_BITS-1:0];
				REG_ITERATION_LIMIT: iteration_limit_q <= cfg.data[LIMIT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pixel.valid) begin
						state_q <= S_MX;
					end
				end
				S_MX: state_q <= S_MY;
				S_MY: state_q <= S_CY;
				S_CY: begin
					state_q <= (limit_eff == '0) ? S_OUT : S_AA;
				end
				S_AA: state_q <= S_BB;
				S_BB: state_q <= S_AB;
				S_AB: state_q <= S_TS;
				S_TS: begin
					if (mag > FOUR) begin
						state_q <= S_DIV;
					end else if (count_inc == limit_eff) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_AA;
					end
				end
				S_DIV: begin
					if (div_step_q == 3'd7) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				px_q  <= pixel.pixel_x;
				py_q  <= pixel.pixel_y;
				tag_q <= pixel.pixel_tag;
			end
			S_MY: cx_q <= clamp_c;
			S_CY: begin
				cy_q     <= clamp_c;
				a_q      <= '0;
				b_q      <= '0;
				count_q  <= '0;
				inside_q <= 1'b1;
			end
			S_BB: aa_q <= SW'(prod_q >>> FRAC_BITS);
			S_AB: bb_q <= SW'(prod_q >>> FRAC_BITS);
			S_TS: begin
				if (mag > FOUR) begin
					inside_q   <= 1'b0;
					rem_q      <= num;
					dsh_q      <= NW'(den) << 7;
					div_step_q <= '0;
				end else begin
					a_q     <= W'(next_a);
					b_q     <= W'(next_b);
					count_q <= count_inc;
				end
			end
			S_DIV: begin
				// One quotient bit per cycle, most significant first.
				if (div_ge) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q      <= {quo_q[COLOR_BITS-2:0], div_ge};
				dsh_q      <= dsh_q >> 1;
				div_step_q <= div_step_q + 1'b1;
			end
			S_OUT: begin
				if (out_free) begin
					res_tag_q    <= tag_q;
					res_in_set_q <= inside_q;
					res_count_q  <= COUNT_OUT_BITS'(count_q);
					res_color_q  <= inside_q ? '0 : quo_q;
				end
			end
			default: ;
		endcase
	end

	a_in_set_color_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_in_set_q |-> res_color_q == '0)
		else $error("in-set result carries a nonzero color index");

	a_in_set_count_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) && res_in_set_q |-> res_count_q == COUNT_OUT_BITS'(limit_eff))
		else $error("in-set result count differs from the limit");

	a_escape_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (count_q < limit_eff) && (count_q != '0))
		else $error("escaped pixel count out of range");

	a_iterate_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AA) |-> count_q < limit_eff)
		else $error("iteration started at or past the limit");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.ready |=> !pixel.ready && state_q == S_MX)
		else $error("pixel word accepted without starting the mapping");

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the escape-time core. Pixel words are sent under a
// series of register settings, from fixed corner cases to random viewing
// windows around the set. Every accepted pixel is run through an integer model
// of the mapping, the iteration and the color divide, and each result word is
// compared with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_top import met_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_BITS    = 12;
	localparam int FRAC_BITS     = 27;
	localparam int COUNT_BITS    = 12;
	localparam int COUNT_MAX     = 2**COUNT_BITS - 1;
	localparam int PIXEL_MAX     = 2**COORD_BITS - 1;
	localparam int RANDOM_PIXELS = 1030;
	localparam int QUIET_PIXELS  = 80;
	localparam int SETTLE_CYCLES = 8;

	localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_UNMAPPED = 8'd4;

	typedef struct packed {
		logic [TAG_BITS-1:0]       result_tag;
		logic                      in_set;
		logic [COUNT_OUT_BITS-1:0] iteration_count;
		logic [COLOR_BITS-1:0]     color_index;
	} escape_word_t;

	class escape_checker;
		logic [CENTER_BITS-1:0] ctr_x;
		logic [CENTER_BITS-1:0] ctr_y;
		logic [SCALE_BITS-1:0]  scale;
		logic [LIMIT_BITS-1:0]  limit;
		escape_word_t           expected_escapes[$];
		int unsigned            error_count;
		int unsigned            checked;
		int unsigned            inside_seen;

		function new();
			ctr_x = CENTER_X_RESET;
			ctr_y = CENTER_Y_RESET;
			scale = PIXEL_SCALE_RESET;
			limit = ITERATION_LIMIT_RESET;
		endfunction

		function void note_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
			case (idx)
				REG_CENTER_X:        ctr_x = value[CENTER_BITS-1:0];
				REG_CENTER_Y:        ctr_y = value[CENTER_BITS-1:0];
				REG_PIXEL_SCALE:     scale = value[SCALE_BITS-1:0];
				REG_ITERATION_LIMIT: limit = value[LIMIT_BITS-1:0];
				default: ;
			endcase
		endfunction

		// Exact product of offset and scale, clamped to +/-8.
		function longint map_axis(logic [COORD_BITS-1:0] pix, logic [CENTER_BITS-1:0] ctr);
			longint pos;
			longint clamp;
			clamp = longint'(8) <<< FRAC_BITS;
			pos = (longint'(pix) - longint'(ctr)) * longint'(scale);
			if (pos > clamp)
				pos = clamp;
			if (pos < -clamp)
				pos = -clamp;
			return pos;
		endfunction

		function escape_word_t compute_escape(logic [COORD_BITS-1:0] x,
			logic [COORD_BITS-1:0] y, logic [TAG_BITS-1:0] tag);
			escape_word_t w;
			longint col_c, row_c, a, b, aa, bb, ab2, radius_sq;
			int unsigned steps, cap;
			bit escaped;
			col_c = map_axis(x, ctr_x);
			row_c = map_axis(y, ctr_y);
			radius_sq = longint'(4) <<< FRAC_BITS;
			cap = (limit > COUNT_MAX) ? COUNT_MAX : limit;
			a = 0;
			b = 0;
			steps = 0;
			escaped = 1'b0;
			// Arithmetic shifts round toward minus infinity, as the core does.
			while (!escaped && steps < cap) begin
				aa = (a * a) >>> FRAC_BITS;
				bb = (b * b) >>> FRAC_BITS;
				if (aa + bb > radius_sq) begin
					escaped = 1'b1;
				end else begin
					ab2 = (a * b) >>> (FRAC_BITS - 1);
					a = aa - bb + row_c;
					b = ab2 + col_c;
					steps++;
				end
			end
			w.result_tag = tag;
			w.in_set = (steps == cap);
			w.iteration_count = steps[COUNT_OUT_BITS-1:0];
			if (!w.in_set && cap >= 2)
				w.color_index = COLOR_BITS'((steps * 255) / (cap - 1));
			else
				w.color_index = '0;
			return w;
		endfunction

		function void note_pixel(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
			logic [TAG_BITS-1:0] tag);
			expected_escapes.push_back(compute_escape(x, y, tag));
		endfunction

		function int pending();
			return expected_escapes.size();
		endfunction

		function void check_result(escape_word_t got);
			escape_word_t want;
			if (expected_escapes.size() == 0) begin
				$error("result word with no pixel outstanding: tag %0h", got.result_tag);
				error_count++;
				return;
			end
			want = expected_escapes.pop_front();
			checked++;
			if (want.in_set)
				inside_seen++;
			if (got.result_tag !== want.result_tag) begin
				$error("result_tag: expected %0h, actual %0h", want.result_tag, got.result_tag);
				error_count++;
			end
			if (got.in_set !== want.in_set) begin
				$error("in_set: expected %0d, actual %0d", want.in_set, got.in_set);
				error_count++;
			end
			if (got.iteration_count !== want.iteration_count) begin
				$error("iteration_count: expected %0d, actual %0d",
					want.iteration_count, got.iteration_count);
				error_count++;
			end
			if (got.color_index !== want.color_index) begin
				$error("color_index: expected %0d, actual %0d", want.color_index, got.color_index);
				error_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	met_pixel_if #(.COORD_BITS(COORD_BITS)) pixel_ch();
	met_result_if result_ch();
	met_cfg_if cfg_ch();

	mandelbrot_escape_time_core #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS),
		.COUNT_BITS(COUNT_BITS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.pixel (pixel_ch),
		.result(result_ch),
		.cfg   (cfg_ch)
	);

	escape_checker board = new();
	bit            idle_on = 1'b0;
	bit            quiet_tail = 1'b0;
	int unsigned   stall_left = 0;
	int unsigned   settings_applied = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("tb_top: errors");
		$finish;
	end

	// Receiver holds off in random bursts, except in the quiet tail or with idling off.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left = stall_left - 1;
			result_ch.ready <= 1'b0;
		end else if (idle_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(0, 3);
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		escape_word_t got;
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			got.result_tag = result_ch.result_tag;
			got.in_set = result_ch.in_set;
			got.iteration_count = result_ch.iteration_count;
			got.color_index = result_ch.color_index;
			board.check_result(got);
		end
	end

	// Valid stays high after acceptance so back-to-back words need one update.
	task automatic send_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
		input logic [TAG_BITS-1:0] tag);
		@(negedge clk);
		if (idle_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
			pixel_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		pixel_ch.valid <= 1'b1;
		pixel_ch.pixel_x <= x;
		pixel_ch.pixel_y <= y;
		pixel_ch.pixel_tag <= tag;
		do @(posedge clk); while (pixel_ch.ready !== 1'b1);
		board.note_pixel(x, y, tag);
	endtask

	task automatic drain_pipeline();
		@(negedge clk);
		pixel_ch.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		board.note_write(idx, value);
	endtask

	// Unused upper data bits carry noise, and a write to an unmapped index
	// must leave every register alone.
	task automatic apply_settings(input int cx, input int cy, input logic [SCALE_BITS-1:0] scl,
		input int lim);
		logic [CFG_DATA_BITS-1:0] noise;
		noise = CFG_DATA_BITS'($urandom);
		write_register(REG_CENTER_X, CFG_DATA_BITS'(cx) | (noise << CENTER_BITS));
		write_register(REG_CENTER_Y, CFG_DATA_BITS'(cy) | (noise << (CENTER_BITS + 1)));
		write_register(CFG_IDX_BITS'($urandom_range(REG_FIRST_UNMAPPED, 2**CFG_IDX_BITS - 1)),
			CFG_DATA_BITS'($urandom));
		write_register(REG_PIXEL_SCALE, scl);
		write_register(REG_ITERATION_LIMIT, CFG_DATA_BITS'(lim) | (noise << LIMIT_BITS));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		settings_applied++;
	endtask

	function automatic int pick_center();
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return 2**CENTER_BITS - 1;
			2:       return $urandom_range(0, 2**CENTER_BITS - 1);
			default: return $urandom_range(0, PIXEL_MAX);
		endcase
	endfunction

	function automatic int pixel_near(int ctr, int reach);
		int pos;
		pos = ctr + int'($urandom_range(0, 2 * reach)) - reach;
		if (pos < 0)
			pos = 0;
		if (pos > PIXEL_MAX)
			pos = PIXEL_MAX;
		return pos;
	endfunction

	initial begin : stimulus
		int cx, cy, lim, reach, phase_len, random_sent;
		logic [SCALE_BITS-1:0] scl;
		bit big_limit_done;

		arst_n = 1'b0;
		pixel_ch.valid = 1'b0;
		pixel_ch.pixel_x = '0;
		pixel_ch.pixel_y = '0;
		pixel_ch.pixel_tag = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: the origin, the corners and a few points on the axes.
		send_pixel(700, 910, 24'h000000);
		send_pixel(0, 0, 24'hFFFFFF);
		send_pixel(4095, 4095, 24'hA5A5A5);
		send_pixel(0, 4095, 24'h5A5A5A);
		send_pixel(4095, 0, 24'h123456);
		send_pixel(100, 910, 24'h000001);
		send_pixel(1300, 910, 24'h800000);
		send_pixel(700, 1510, 24'h7FFFFF);
		drain_pipeline();

		// Limit zero with the largest scale; the far corner drives both parts into the clamp.
		apply_settings(0, 0, '1, 0);
		send_pixel(0, 0, 24'h000010);
		send_pixel(4095, 4095, 24'h000011);
		send_pixel(1, 4095, 24'h000012);
		drain_pipeline();

		// Limit one, centers at their top, smallest nonzero scale.
		apply_settings(2**CENTER_BITS - 1, 2**CENTER_BITS - 1, SCALE_BITS'(1), 1);
		send_pixel(0, 0, 24'h000020);
		send_pixel(4095, 4095, 24'h000021);
		drain_pipeline();

		// Scale zero puts every pixel at the origin.
		apply_settings(4095, 0, '0, 2);
		send_pixel(0, 0, 24'h000030);
		send_pixel(2047, 2048, 24'h000031);
		send_pixel(4095, 4095, 24'h000032);
		drain_pipeline();

		apply_settings(1, 2, 28'd134217728, 3);
		send_pixel(1, 2, 24'h000040);
		send_pixel(2, 2, 24'h000041);
		send_pixel(1, 3, 24'h000042);
		send_pixel(0, 2, 24'h000043);
		drain_pipeline();

		// Largest limit: the center runs the counter all the way up.
		apply_settings(2048, 2048, 28'd67108864, COUNT_MAX);
		send_pixel(2048, 2048, 24'h000050);
		send_pixel(2047, 2048, 24'h000051);
		send_pixel(2052, 2048, 24'h000052);
		send_pixel(2049, 2049, 24'h000053);
		drain_pipeline();

		random_sent = 0;
		big_limit_done = 1'b0;
		while (random_sent < RANDOM_PIXELS) begin
			case ($urandom_range(0, 7))
				0:         lim = $urandom_range(0, 3);
				1, 2:      lim = $urandom_range(4, 30);
				3, 4, 5:   lim = $urandom_range(31, 100);
				default:   lim = 100;
			endcase
			case ($urandom_range(0, 9))
				0:       scl = '0;
				1:       scl = SCALE_BITS'(1);
				2:       scl = '1;
				3:       scl = SCALE_BITS'($urandom);
				4:       scl = 28'd134217728;
				default: scl = SCALE_BITS'($urandom_range(65536, 8388608));
			endcase
			cx = pick_center();
			cy = pick_center();
			phase_len = $urandom_range(25, 70);
			// One short stretch with a deep limit; the rest stay cheap.
			if (!big_limit_done && random_sent > 400) begin
				lim = $urandom_range(1000, COUNT_MAX);
				scl = SCALE_BITS'($urandom_range(65536, 1048576));
				phase_len = 5;
				big_limit_done = 1'b1;
			end
			reach = (scl == 0) ? PIXEL_MAX : int'((longint'(3) <<< FRAC_BITS) / scl);
			if (reach > PIXEL_MAX)
				reach = PIXEL_MAX;
			apply_settings(cx, cy, scl, lim);
			idle_on = ($urandom_range(0, 4) != 0);
			for (int k = 0; k < phase_len && random_sent < RANDOM_PIXELS; k++) begin
				quiet_tail = (random_sent >= RANDOM_PIXELS - QUIET_PIXELS);
				if ($urandom_range(0, 149) == 0)
					drain_pipeline();
				// Most pixels fall in a window around the set, the rest anywhere.
				if ($urandom_range(0, 3) != 0)
					send_pixel(COORD_BITS'(pixel_near(cx, reach)),
						COORD_BITS'(pixel_near(cy, reach)), TAG_BITS'($urandom));
				else
					send_pixel(COORD_BITS'($urandom), COORD_BITS'($urandom),
						TAG_BITS'($urandom));
				random_sent++;
			end
			drain_pipeline();
		end

		repeat (20) @(posedge clk);
		$display("summary: %0d result words checked, %0d inside the set, %0d escaped",
			board.checked, board.inside_seen, board.checked - board.inside_seen);
		$display("summary: %0d register settings applied, including limits 0, 1 and %0d",
			settings_applied, COUNT_MAX);
		if (board.error_count == 0 && board.pending() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/met_pkg.sv
rtl/core/met_if.sv
rtl/core/mandelbrot_escape_time_core.sv
dv/tb_top.sv
